// ----- src/aabb_group_pair_collision_table_unit_macros.svh -----
// Assertion macros for the collision table unit.
`ifndef AABB_GROUP_PAIR_COLLISION_TABLE_UNIT_MACROS_SVH
`define AABB_GROUP_PAIR_COLLISION_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define AGPCT_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, active during reset as well.
`define AGPCT_ASSERT_NEXT(label, clk, cond, expr, msg) \
   label: assert property (@(posedge clk) (cond) |=> (expr)) else $error(msg);

`endif

// ----- src/agpct_pkg.sv -----
`default_nettype none
package agpct_pkg;

   localparam int COORD_BITS  = 16;
   localparam int SIZE_BITS   = COORD_BITS - 1;
   localparam int ID_BITS     = 8;
   localparam int GROUP_BITS  = 4;
   localparam int EXT_BITS    = COORD_BITS + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // command codes on the request beat
   localparam logic [1:0] CMD_REGISTER   = 2'd0;
   localparam logic [1:0] CMD_UNREGISTER = 2'd1;
   localparam logic [1:0] CMD_MOVE       = 2'd2;
   localparam logic [1:0] CMD_SWEEP      = 2'd3;

   // status codes on the response beat
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_PAIR      = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [1:0]                   command;
      logic [ID_BITS-1:0]           object_id;
      logic [GROUP_BITS-1:0]        group_id;
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic [SIZE_BITS-1:0]         size_w;
      logic [SIZE_BITS-1:0]         size_h;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [ID_BITS-1:0] first_id;
      logic [ID_BITS-1:0] second_id;
      logic               last;
   } rsp_item_type;

   typedef enum logic [1:0] {
      OP_REGISTER,
      OP_UNREGISTER,
      OP_MOVE,
      OP_SWEEP
   } op_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] left;
      logic signed [COORD_BITS-1:0] top;
      logic [SIZE_BITS-1:0]         width;
      logic [SIZE_BITS-1:0]         height;
   } geom_type;

   // classified command held in the queue
   typedef struct packed {
      op_type                op;
      logic [ID_BITS-1:0]    object;
      logic [GROUP_BITS-1:0] group;
      geom_type              geom;
   } cmd_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    object;
      logic [GROUP_BITS-1:0] group;
      geom_type              geom;
   } entry_type;

   // queue to back handshake
   typedef struct packed {
      logic    valid;
      cmd_type head;
   } queue_out_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_WALK,
      BK_SWEEP,
      BK_TAIL,
      BK_FLUSH
   } back_state_type;

endpackage
`default_nettype wire

// ----- src/aabb_group_pair_collision_table_unit.sv -----
`default_nettype none
// Box table with group-wise all-pairs overlap sweep. A command beat is taken
// when start is high and busy is low; it goes through a one-beat front
// register into a two-entry command queue, so busy rises only when both are
// full. Responses come out on rsp_valid for exactly one cycle each and cannot
// be held off. Every command gives one response with last set, except a
// sweep, which gives one response per overlapping pair (lower slot first,
// ascending slot pairs) with last on the final one, or a single done response
// when no pair overlaps. The back end reads the table through its two read
// ports, one table access per cycle. Register is done straight from the queue
// head; unregister and move read and compare each slot's object id in turn;
// sweep tests one slot pair per cycle (28 pair tests at eight slots). An
// accepted beat passes the front register and the command queue before the
// back end takes it.
module aabb_group_pair_collision_table_unit #(
   parameter int TABLE_ENTRIES = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  agpct_pkg::req_item_type req_item,
   output logic                    busy,
   output logic                    rsp_valid,
   output agpct_pkg::rsp_item_type rsp_item
);
   import agpct_pkg::*;

`include "aabb_group_pair_collision_table_unit_macros.svh"

   logic          push;
   cmd_type       push_cmd;
   logic          q_full;
   logic          q_pop;
   queue_out_type q_out;

   // front: takes the beat and decodes the command
   agpct_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .q_full   (q_full),
      .busy     (busy),
      .push     (push),
      .push_cmd (push_cmd)
   );

   // decoupling queue between front and back
   agpct_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .q_out    (q_out)
   );

   // back: owns the box table, runs commands and sweeps
   agpct_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_out     (q_out),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // back end only pulls a command that the queue holds
   `AGPCT_ASSERT_IMPLY(a_pop_has_head, clock, reset, q_pop, q_out.valid, "pop on empty queue")
   // anything but a pair response closes out its command
   `AGPCT_ASSERT_IMPLY(a_nonpair_last, clock, reset, rsp_valid && rsp_item.status != ST_PAIR, rsp_item.last, "non-pair response without last")
   // ids are only carried by pair responses
   `AGPCT_ASSERT_IMPLY(a_nonpair_ids, clock, reset, rsp_valid && rsp_item.status != ST_PAIR, rsp_item.first_id == '0 && rsp_item.second_id == '0, "ids on non-pair response")
   // reset leaves the block quiet and ready
   `AGPCT_ASSERT_NEXT(a_reset_quiet, clock, reset, !rsp_valid && !busy, "not idle after reset")

endmodule
`default_nettype wire

// ----- src/agpct_front.sv -----
`default_nettype none
module agpct_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  agpct_pkg::req_item_type req_item,
   input  logic                    q_full,
   output logic                    busy,
   output logic                    push,
   output agpct_pkg::cmd_type      push_cmd
);
   import agpct_pkg::*;

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_cmd_ff, hold_cmd_in;
   logic    accept;
   op_type  op_dec;

   always_comb begin
      case (req_item.command)
         CMD_REGISTER:   op_dec = OP_REGISTER;
         CMD_UNREGISTER: op_dec = OP_UNREGISTER;
         CMD_MOVE:       op_dec = OP_MOVE;
         default:        op_dec = OP_SWEEP;
      endcase
   end

   assign busy     = hold_valid_ff && q_full;
   assign accept   = start && !busy;
   assign push     = hold_valid_ff && !q_full;
   assign push_cmd = hold_cmd_ff;

   always_comb begin
      hold_cmd_in = hold_cmd_ff;
      if (accept) begin
         hold_cmd_in.op          = op_dec;
         hold_cmd_in.object      = req_item.object_id;
         hold_cmd_in.group       = req_item.group_id;
         hold_cmd_in.geom.left   = req_item.pos_x;
         hold_cmd_in.geom.top    = req_item.pos_y;
         hold_cmd_in.geom.width  = req_item.size_w;
         hold_cmd_in.geom.height = req_item.size_h;
      end
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (push) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_cmd_ff <= hold_cmd_in;
   end

endmodule
`default_nettype wire

// ----- src/agpct_queue.sv -----
`default_nettype none
module agpct_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  agpct_pkg::cmd_type        push_cmd,
   output logic                      full,
   input  logic                      pop,
   output agpct_pkg::queue_out_type  q_out
);
   import agpct_pkg::*;

   cmd_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  do_push, do_pop;

   localparam logic [QPTR_BITS-1:0] PTR_END = QPTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_BITS-1:0] CNT_MAX = QCNT_BITS'(QUEUE_DEPTH);

   assign full        = (count_ff == CNT_MAX);
   assign q_out.valid = (count_ff != '0);
   assign q_out.head  = slot_ff[rd_ptr_ff];
   assign do_push     = push && !full;
   assign do_pop      = pop && q_out.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_END) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_END) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ----- src/agpct_back.sv -----
`default_nettype none
module agpct_back #(
   parameter int TABLE_ENTRIES = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  agpct_pkg::queue_out_type q_out,
   output logic                     pop,
   output logic                     rsp_valid,
   output agpct_pkg::rsp_item_type  rsp_item
);
   import agpct_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [IDX_W-1:0] PEN_IDX  = IDX_W'(TABLE_ENTRIES - 2);

   back_state_type state_ff, state_in;

   // box table: one write port, two registered read ports
   entry_type entry_ff [TABLE_ENTRIES];
   entry_type rd_a_ff, rd_b_ff;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   entry_type            mem_wdata;

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   cmd_type              op_ff, op_in;
   logic [IDX_W-1:0]     i_ff, i_in, j_ff, j_in;
   logic                 s1_live_ff, s1_live_in;
   logic                 s1_end_ff, s1_end_in;
   logic [IDX_W-1:0]     s1_i_ff, s1_i_in, s1_j_ff, s1_j_in;
   logic                 hit_ff, hit_in;
   logic                 hold_valid_ff, hold_valid_in;
   logic [ID_BITS-1:0]   hold_first_ff, hold_first_in;
   logic [ID_BITS-1:0]   hold_second_ff, hold_second_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_item_ff, rsp_item_in;

   logic                 walk_end, sweep_end;
   logic                 free_found;
   logic [IDX_W-1:0]     free_slot;
   logic                 slot_match, pair_hit, overlap;
   logic signed [EXT_BITS-1:0] a_left, a_top, a_right, a_bottom;
   logic signed [EXT_BITS-1:0] b_left, b_top, b_right, b_bottom;

   assign walk_end  = (i_ff == LAST_IDX);
   assign sweep_end = (j_ff == LAST_IDX) && (i_ff == PEN_IDX);

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
         if (!valid_ff[k]) begin
            free_found = 1'b1;
            free_slot  = IDX_W'(k);
         end
      end
   end

   // edges widened by one bit so right and bottom cannot wrap
   always_comb begin
      a_left   = $signed({rd_a_ff.geom.left[COORD_BITS-1], rd_a_ff.geom.left});
      a_top    = $signed({rd_a_ff.geom.top[COORD_BITS-1], rd_a_ff.geom.top});
      a_right  = a_left + $signed({2'b00, rd_a_ff.geom.width});
      a_bottom = a_top + $signed({2'b00, rd_a_ff.geom.height});
      b_left   = $signed({rd_b_ff.geom.left[COORD_BITS-1], rd_b_ff.geom.left});
      b_top    = $signed({rd_b_ff.geom.top[COORD_BITS-1], rd_b_ff.geom.top});
      b_right  = b_left + $signed({2'b00, rd_b_ff.geom.width});
      b_bottom = b_top + $signed({2'b00, rd_b_ff.geom.height});
      overlap  = !(a_bottom < b_top) && !(a_top > b_bottom) &&
                 !(a_right < b_left) && !(a_left > b_right);
   end

   assign slot_match = valid_ff[s1_i_ff] && (rd_a_ff.object == op_ff.object);
   assign pair_hit   = valid_ff[s1_i_ff] && valid_ff[s1_j_ff] &&
                       (rd_a_ff.group == rd_b_ff.group) && overlap;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_out.valid) begin
               case (q_out.head.op)
                  OP_UNREGISTER, OP_MOVE: state_in = BK_WALK;
                  OP_SWEEP:               state_in = BK_SWEEP;
                  default:                state_in = BK_IDLE;
               endcase
            end
         end
         BK_WALK: begin
            if (walk_end) state_in = BK_TAIL;
         end
         BK_SWEEP: begin
            if (sweep_end) state_in = BK_TAIL;
         end
         BK_TAIL: begin
            state_in = (op_ff.op == OP_SWEEP) ? BK_FLUSH : BK_IDLE;
         end
         BK_FLUSH: state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pop            = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = '0;
      mem_wdata      = '0;
      valid_in       = valid_ff;
      op_in          = op_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      s1_live_in     = 1'b0;
      s1_end_in      = 1'b0;
      s1_i_in        = s1_i_ff;
      s1_j_in        = s1_j_ff;
      hit_in         = hit_ff;
      hold_valid_in  = hold_valid_ff;
      hold_first_in  = hold_first_ff;
      hold_second_in = hold_second_ff;
      rsp_valid_in   = 1'b0;
      rsp_item_in    = '0;

      case (state_ff)
         BK_IDLE: begin
            pop = q_out.valid;
            if (q_out.valid) begin
               op_in         = q_out.head;
               i_in          = '0;
               j_in          = IDX_W'(1);
               hit_in        = 1'b0;
               hold_valid_in = 1'b0;
               if (q_out.head.op == OP_REGISTER) begin
                  rsp_valid_in     = 1'b1;
                  rsp_item_in.last = 1'b1;
                  if (free_found) begin
                     mem_we              = 1'b1;
                     mem_waddr           = free_slot;
                     mem_wdata.object    = q_out.head.object;
                     mem_wdata.group     = q_out.head.group;
                     mem_wdata.geom      = q_out.head.geom;
                     valid_in[free_slot] = 1'b1;
                     rsp_item_in.status  = ST_DONE;
                  end else begin
                     rsp_item_in.status  = ST_FULL;
                  end
               end
            end
         end
         BK_WALK: begin
            s1_live_in = 1'b1;
            s1_end_in  = walk_end;
            s1_i_in    = i_ff;
            if (!walk_end) i_in = i_ff + 1'b1;
         end
         BK_SWEEP: begin
            s1_live_in = 1'b1;
            s1_end_in  = sweep_end;
            s1_i_in    = i_ff;
            s1_j_in    = j_ff;
            if (j_ff != LAST_IDX) begin
               j_in = j_ff + 1'b1;
            end else if (!sweep_end) begin
               i_in = i_ff + 1'b1;
               j_in = i_ff + IDX_W'(2);
            end
         end
         BK_FLUSH: begin
            rsp_valid_in     = 1'b1;
            rsp_item_in.last = 1'b1;
            if (hold_valid_ff) begin
               rsp_item_in.status    = ST_PAIR;
               rsp_item_in.first_id  = hold_first_ff;
               rsp_item_in.second_id = hold_second_ff;
            end else begin
               rsp_item_in.status    = ST_DONE;
            end
            hold_valid_in = 1'b0;
         end
         default: begin
         end
      endcase

      // second stage: read data of the previous issue
      if (s1_live_ff) begin
         if (op_ff.op == OP_SWEEP) begin
            if (pair_hit) begin
               // pair held back one find so the final one can carry last
               if (hold_valid_ff) begin
                  rsp_valid_in          = 1'b1;
                  rsp_item_in.status    = ST_PAIR;
                  rsp_item_in.first_id  = hold_first_ff;
                  rsp_item_in.second_id = hold_second_ff;
                  rsp_item_in.last      = 1'b0;
               end
               hold_valid_in  = 1'b1;
               hold_first_in  = rd_a_ff.object;
               hold_second_in = rd_b_ff.object;
            end
         end else begin
            if (slot_match) begin
               hit_in = 1'b1;
               if (op_ff.op == OP_UNREGISTER) begin
                  valid_in[s1_i_ff] = 1'b0;
               end else begin
                  mem_we           = 1'b1;
                  mem_waddr        = s1_i_ff;
                  mem_wdata.object = rd_a_ff.object;
                  mem_wdata.group  = rd_a_ff.group;
                  mem_wdata.geom   = op_ff.geom;
               end
            end
            if (s1_end_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_item_in.status = (hit_ff || slot_match) ? ST_DONE : ST_NOT_FOUND;
               rsp_item_in.last   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_ff[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= entry_ff[i_ff];
      rd_b_ff <= entry_ff[j_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         valid_ff      <= '0;
         s1_live_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         s1_live_ff    <= s1_live_in;
         hit_ff        <= hit_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff          <= op_in;
      i_ff           <= i_in;
      j_ff           <= j_in;
      s1_end_ff      <= s1_end_in;
      s1_i_ff        <= s1_i_in;
      s1_j_ff        <= s1_j_in;
      hold_first_ff  <= hold_first_in;
      hold_second_ff <= hold_second_in;
      rsp_item_ff    <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none
// Checks the box table against a cycle-free software copy of its behavior.
// Every command beat accepted on start/busy is run through box_table_predict,
// which updates a private copy of the table and queues the response beats the
// block must give for it. The response monitor pops one expected beat per
// rsp_valid strobe and compares it field by field. Directed tests come first:
// empty table, extremes of coordinates and sizes, touching edges, wrap-free
// edge sums, duplicate ids, a full table, move keeping the group, and misses.
// Random traffic follows in three sender pacing phases.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import agpct_pkg::*;

   localparam int SLOTS        = 8;
   // slowest command is a sweep of 28 pair tests, plus the way through the front
   // register and command queue; leave some slack on top
   localparam int DRAIN_CYCLES = 40;
   // about 150 beats, each with up to 28 responses and a capped sender gap;
   // the limit is set well above what the slowest run needs
   localparam int CYCLE_LIMIT  = 200000;
   localparam int POOL_SIZE    = 12;
   // small id pool so unregister and move hit most of the time
   localparam logic [POOL_SIZE*ID_BITS-1:0] ID_POOL = {
      8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF, 8'h3C,
      8'hC3, 8'h5A, 8'hA5, 8'h10, 8'h11, 8'hEE
   };

   // one table slot; edges kept as ints so right/bottom never wrap
   typedef struct {
      bit                    used;
      logic [ID_BITS-1:0]    object;
      logic [GROUP_BITS-1:0] group;
      int                    left;
      int                    top;
      int                    right;
      int                    bottom;
   } box_slot_type;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   req_item_type req_item = '0;
   logic         busy;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   box_slot_type box_table [SLOTS];
   rsp_item_type awaited_rsp [$];
   int           sender_idle_pct = 0;
   bit           failed          = 1'b0;
   int unsigned  cycle_count     = 0;

   aabb_group_pair_collision_table_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // corner and size into a slot; the group is left alone (move keeps it)
   function automatic void place_box(int slot, req_item_type beat);
      int w;
      int h;
      w = int'(beat.size_w);
      h = int'(beat.size_h);
      box_table[slot].left   = int'(beat.pos_x);
      box_table[slot].top    = int'(beat.pos_y);
      box_table[slot].right  = box_table[slot].left + w;
      box_table[slot].bottom = box_table[slot].top + h;
   endfunction

   // applies one command to the table copy and queues its response beats
   function automatic void box_table_predict(req_item_type beat);
      rsp_item_type r;
      rsp_item_type held;
      bit           done;
      bit           have_pair;
      box_slot_type a;
      box_slot_type b;
      r      = '0;
      r.last = 1'b1;
      done   = 1'b0;
      case (beat.command)
         CMD_REGISTER: begin
            // lowest free slot wins; duplicate ids are fine
            for (int i = 0; i < SLOTS; i++) begin
               if (!done && !box_table[i].used) begin
                  box_table[i].used   = 1'b1;
                  box_table[i].object = beat.object_id;
                  box_table[i].group  = beat.group_id;
                  place_box(i, beat);
                  done = 1'b1;
               end
            end
            r.status = done ? ST_DONE : ST_FULL;
            awaited_rsp.push_back(r);
         end
         CMD_UNREGISTER, CMD_MOVE: begin
            // every slot with the id is hit, not just the first
            for (int i = 0; i < SLOTS; i++) begin
               if (box_table[i].used && box_table[i].object == beat.object_id) begin
                  done = 1'b1;
                  if (beat.command == CMD_UNREGISTER)
                     box_table[i].used = 1'b0;
                  else
                     place_box(i, beat);
               end
            end
            r.status = done ? ST_DONE : ST_NOT_FOUND;
            awaited_rsp.push_back(r);
         end
         default: begin
            // sweep: pairs i < j in the same group, touching counts as overlap.
            // Each pair is held back one step so the final one gets last.
            have_pair = 1'b0;
            held      = '0;
            for (int i = 0; i < SLOTS; i++) begin
               for (int j = i + 1; j < SLOTS; j++) begin
                  a = box_table[i];
                  b = box_table[j];
                  if (a.used && b.used && a.group == b.group &&
                      !(a.bottom < b.top || a.top > b.bottom ||
                        a.right < b.left || a.left > b.right)) begin
                     if (have_pair)
                        awaited_rsp.push_back(held);
                     held.status    = ST_PAIR;
                     held.first_id  = a.object;
                     held.second_id = b.object;
                     held.last      = 1'b0;
                     have_pair      = 1'b1;
                  end
               end
            end
            if (have_pair) begin
               held.last = 1'b1;
               awaited_rsp.push_back(held);
            end else begin
               r.status = ST_DONE;
               awaited_rsp.push_back(r);
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Response monitor
   // ---------------------------------------------------------------------

   task automatic flag_mismatch(string field, int want_v, int got_v);
      failed = 1'b1;
      $display("%0t ns: %s expected %0d got %0d", $time, field, want_v, got_v);
   endtask

   // results cannot be held off, so every strobe is taken at the edge
   always @(posedge clock) begin : rsp_monitor
      rsp_item_type want;
      if (!reset && rsp_valid) begin
         if (awaited_rsp.size() == 0) begin
            flag_mismatch("unexpected beat, status", -1, int'(rsp_item.status));
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_item.status !== want.status)
               flag_mismatch("status", int'(want.status), int'(rsp_item.status));
            if (rsp_item.first_id !== want.first_id)
               flag_mismatch("first_id", int'(want.first_id), int'(rsp_item.first_id));
            if (rsp_item.second_id !== want.second_id)
               flag_mismatch("second_id", int'(want.second_id), int'(rsp_item.second_id));
            if (rsp_item.last !== want.last)
               flag_mismatch("last", int'(want.last), int'(rsp_item.last));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Called at a rising edge. Optional idle gap first, then hold start until
   // the edge where busy is low; start stays high on return so back-to-back
   // beats never drop it.
   task automatic send_beat(req_item_type beat);
      int gap;
      gap = 0;
      while (gap < 16 && $urandom_range(99) < sender_idle_pct)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= beat;
      do @(posedge clock); while (busy);
      box_table_predict(beat);
   endtask

   function automatic req_item_type beat_of(logic [1:0] cmd, logic [7:0] id,
                                            logic [3:0] grp, int x, int y,
                                            int w, int h);
      req_item_type b;
      b.command   = cmd;
      b.object_id = id;
      b.group_id  = grp;
      b.pos_x     = 16'(x);
      b.pos_y     = 16'(y);
      b.size_w    = 15'(w);
      b.size_h    = 15'(h);
      return b;
   endfunction

   function automatic logic signed [15:0] random_coord();
      if ($urandom_range(99) < 8)
         return 16'($urandom);
      return 16'(int'($urandom_range(160)) - 80);
   endfunction

   function automatic logic [14:0] random_size();
      if ($urandom_range(99) < 8)
         return 15'($urandom);
      return 15'($urandom_range(48));
   endfunction

   // mostly sane commands on a crowded patch; some beats are pure noise
   function automatic req_item_type random_beat();
      req_item_type b;
      int           pick;
      if ($urandom_range(99) < 15) begin
         b.command   = 2'($urandom);
         b.object_id = 8'($urandom);
         b.group_id  = 4'($urandom);
         b.pos_x     = 16'($urandom);
         b.pos_y     = 16'($urandom);
         b.size_w    = 15'($urandom);
         b.size_h    = 15'($urandom);
         return b;
      end
      pick = $urandom_range(99);
      if (pick < 30)
         b.command = CMD_REGISTER;
      else if (pick < 45)
         b.command = CMD_UNREGISTER;
      else if (pick < 65)
         b.command = CMD_MOVE;
      else
         b.command = CMD_SWEEP;
      pick        = $urandom_range(POOL_SIZE - 1);
      b.object_id = ID_POOL[pick*ID_BITS +: ID_BITS];
      b.group_id  = 4'($urandom_range(2));
      b.pos_x     = random_coord();
      b.pos_y     = random_coord();
      b.size_w    = random_size();
      b.size_h    = random_size();
      return b;
   endfunction

   // sweep and misses on a table nobody has written
   task automatic test_empty_table();
      send_beat(beat_of(CMD_SWEEP, 8'h3C, 4'h9, -5, 7, 3, 4));
      send_beat(beat_of(CMD_UNREGISTER, 8'h00, 4'h0, 0, 0, 0, 0));
      send_beat(beat_of(CMD_MOVE, 8'hFF, 4'hF, 32767, -32768, 32767, 32767));
   endtask

   // eight boxes at the extremes, then one more than fits
   task automatic test_fill_and_overflow();
      // corner-to-corner touch at (-1,-1)
      send_beat(beat_of(CMD_REGISTER, 8'h00, 4'h0, -32768, -32768, 32767, 32767));
      send_beat(beat_of(CMD_REGISTER, 8'hFF, 4'h0, -1, -1, 0, 0));
      // right edge 65534 must not wrap; touches the next box at x = 32767
      send_beat(beat_of(CMD_REGISTER, 8'h55, 4'hF, 32767, 32767, 32767, 32767));
      send_beat(beat_of(CMD_REGISTER, 8'hAA, 4'hF, 0, 0, 32767, 32767));
      // duplicate id, one past the first box's corner
      send_beat(beat_of(CMD_REGISTER, 8'h55, 4'h0, 0, 0, 0, 0));
      // off by one on x: no pair
      send_beat(beat_of(CMD_REGISTER, 8'h12, 4'h5, 100, 100, 10, 10));
      send_beat(beat_of(CMD_REGISTER, 8'h34, 4'h5, 111, 100, 5, 5));
      // same box as slot 5 but another group: no pair
      send_beat(beat_of(CMD_REGISTER, 8'h56, 4'h6, 100, 100, 10, 10));
      send_beat(beat_of(CMD_REGISTER, 8'h99, 4'h6, 100, 100, 10, 10));
      send_beat(beat_of(CMD_SWEEP, 8'h00, 4'h0, 0, 0, 0, 0));
   endtask

   task automatic test_move_and_remove();
      // both slots of the duplicate id move; group field is ignored
      send_beat(beat_of(CMD_MOVE, 8'h55, 4'h3, -40, -40, 100, 100));
      send_beat(beat_of(CMD_SWEEP, 8'hFF, 4'hF, -1, -1, 32767, 32767));
      // unregister with junk geometry removes both
      send_beat(beat_of(CMD_UNREGISTER, 8'h55, 4'hA, 1234, -4321, 77, 88));
      send_beat(beat_of(CMD_SWEEP, 8'h00, 4'h0, 0, 0, 0, 0));
      // refills the lowest free slot; zero-height sliver touching two boxes
      send_beat(beat_of(CMD_REGISTER, 8'h80, 4'h5, 110, 105, 1, 0));
      send_beat(beat_of(CMD_SWEEP, 8'h00, 4'h0, 0, 0, 0, 0));
      send_beat(beat_of(CMD_UNREGISTER, 8'h55, 4'h0, 0, 0, 0, 0));
      send_beat(beat_of(CMD_UNREGISTER, 8'h80, 4'h5, 0, 0, 0, 0));
   endtask

   task automatic test_random_traffic(int idle_pct, int beats);
      sender_idle_pct = idle_pct;
      for (int n = 0; n < beats; n++)
         send_beat(random_beat());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct = 0;
      test_empty_table();
      test_fill_and_overflow();
      sender_idle_pct = 54;
      test_move_and_remove();

      test_random_traffic(0, 43);
      test_random_traffic(54, 43);
      test_random_traffic(10, 43);

      start <= 1'b0;
      while (awaited_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed && awaited_rsp.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // hung block or lost responses
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire
